FILE: src/quoted_argument_tokenizer_unit_defines.svh
// Assertion macros for the quoted argument tokenizer checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QAT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qat: implication check failed");

// Next-cycle implication.
`define QAT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qat: next-cycle check failed");

`endif

FILE: src/qat_pkg.sv
// Shared types and character constants for the quoted argument tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package qat_pkg;

	typedef enum logic [2:0] {
		KIND_BYTE             = 3'd0,
		KIND_TOKEN_END        = 3'd1,
		KIND_STRING_END       = 3'd2,
		KIND_TOKEN_STRING_END = 3'd3,
		KIND_ESCAPE_ERROR     = 3'd4,
		KIND_OPEN_SINGLE      = 3'd5,
		KIND_OPEN_DOUBLE      = 3'd6
	} kind_t;

	localparam logic [7:0] CHAR_NUL       = 8'h00;
	localparam logic [7:0] CHAR_TAB       = 8'h09;
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
	localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

	// Scanner state carried from byte to byte
	typedef struct packed {
		logic in_single;
		logic in_double;
		logic escape;
		logic content;
	} flags_t;

	// Outcome of one byte
	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] char_out;
	} step_res_t;

endpackage

FILE: src/qat_step.sv
// Per-byte decision logic: next scanner flags and the optional result.
// Depends on qat_pkg.
`timescale 1ns / 1ps

module qat_step (
	input  qat_pkg::flags_t    flags,
	input  logic [7:0]         char_in,
	output qat_pkg::flags_t    flags_nxt,
	output qat_pkg::step_res_t res
);

	always_comb begin
		flags_nxt    = flags;
		res.emit     = 1'b0;
		res.kind     = qat_pkg::KIND_BYTE;
		res.char_out = '0;

		if (flags.escape) begin
			if (char_in == qat_pkg::CHAR_NUL) begin
				flags_nxt = '0;
				res.emit  = 1'b1;
				res.kind  = qat_pkg::KIND_ESCAPE_ERROR;
			end else begin
				flags_nxt.escape  = 1'b0;
				flags_nxt.content = 1'b1;
				res.emit          = 1'b1;
				res.char_out      = char_in;
			end
		end else begin
			case (char_in)
				qat_pkg::CHAR_BACKSLASH: begin
					flags_nxt.escape  = 1'b1;
					flags_nxt.content = 1'b1;
				end
				qat_pkg::CHAR_SQUOTE: begin
					flags_nxt.content = 1'b1;
					if (!flags.in_double) begin
						flags_nxt.in_single = !flags.in_single;
					end else begin
						res.emit     = 1'b1;
						res.char_out = char_in;
					end
				end
				qat_pkg::CHAR_DQUOTE: begin
					flags_nxt.content = 1'b1;
					if (!flags.in_single) begin
						flags_nxt.in_double = !flags.in_double;
					end else begin
						res.emit     = 1'b1;
						res.char_out = char_in;
					end
				end
				qat_pkg::CHAR_SPACE, qat_pkg::CHAR_TAB, qat_pkg::CHAR_NEWLINE: begin
					if (flags.in_single || flags.in_double) begin
						res.emit     = 1'b1;
						res.char_out = char_in;
					end else if (flags.content) begin
						flags_nxt.content = 1'b0;
						res.emit          = 1'b1;
						res.kind          = qat_pkg::KIND_TOKEN_END;
					end
				end
				qat_pkg::CHAR_NUL: begin
					flags_nxt = '0;
					res.emit  = 1'b1;
					if (flags.in_single)
						res.kind = qat_pkg::KIND_OPEN_SINGLE;
					else if (flags.in_double)
						res.kind = qat_pkg::KIND_OPEN_DOUBLE;
					else if (flags.content)
						res.kind = qat_pkg::KIND_TOKEN_STRING_END;
					else
						res.kind = qat_pkg::KIND_STRING_END;
				end
				default: begin
					flags_nxt.content = 1'b1;
					res.emit          = 1'b1;
					res.char_out      = char_in;
				end
			endcase
		end
	end

endmodule

FILE: src/quoted_argument_tokenizer_unit.sv
// Shell-style argument splitter: one string byte in per transfer, at most one
// result per byte. Throughput is one byte per clock while the result register
// is not stalled. A byte is held in the input register and decoded into the
// result register once that register can load; its result (if any) is then
// offered from there. The byte leaves the input register only while the result
// register can be emptied; the input register refills whenever it is empty or
// its byte moves on. Bytes are decoded against four flag bits (single quote,
// double quote, pending backslash, token has content); a zero byte ends the
// string and clears every flag. Results: kind 0 carries a literal token byte
// in char_out, kinds 1..6 mark token end, string end, combined end, trailing
// backslash, and unterminated single or double quote (char_out zero).
// Depends on qat_pkg and qat_step.
`timescale 1ns / 1ps

module quoted_argument_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	// byte channel
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_in,
	// result channel
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] kind,
	output logic [7:0] char_out
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;

	// scanner flags
	qat_pkg::flags_t flags_q;
	qat_pkg::flags_t flags_nxt;

	// result register
	logic           res_valid_q;
	qat_pkg::kind_t kind_q;
	logic [7:0]     char_q;

	qat_pkg::step_res_t step;

	logic out_free;   // result register can load this cycle
	logic s1_free;    // input register can load this cycle
	logic take_s1;    // byte in s1 is consumed this cycle

	assign out_free   = !res_valid_q || !res_stall;
	assign s1_free    = !valid_s1 || out_free;
	assign take_s1    = valid_s1 && out_free;
	assign char_stall = !s1_free;

	qat_step u_step (
		.flags     (flags_q),
		.char_in   (char_s1),
		.flags_nxt (flags_nxt),
		.res       (step)
	);

	// Input register: takes a new byte whenever it is empty or the previous one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && char_valid) begin
			char_s1 <= char_in;
		end
	end

	// Flags advance once per consumed byte, result or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (take_s1) begin
			flags_q <= flags_nxt;
		end
	end

	// Result register: holds while stalled, reloads or empties otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= take_s1 && step.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && step.emit) begin
			kind_q <= step.kind;
			char_q <= step.char_out;
		end
	end

	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign char_out  = char_q;

endmodule

FILE: src/qat_checker.sv
// Port-level checks for quoted_argument_tokenizer_unit, bound to the top level.
// Depends on qat_pkg and quoted_argument_tokenizer_unit_defines.svh.
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_unit_defines.svh"

module qat_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       char_stall,
	input logic       res_valid,
	input logic       res_stall,
	input logic [2:0] kind,
	input logic [7:0] char_out
);

	// a stalled result stays offered with the same contents
	`QAT_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable({kind, char_out}))
	// only a full, stalled result register can back up the byte side
	`QAT_ASSERT_IMPL(a_stall_cause, char_stall, res_valid)
	// token bytes are never zero; markers carry no byte
	`QAT_ASSERT_IMPL(a_byte_nonzero, res_valid && kind == qat_pkg::KIND_BYTE, char_out != 8'h00)
	`QAT_ASSERT_IMPL(a_marker_zero, res_valid && kind != qat_pkg::KIND_BYTE, char_out == 8'h00)
	`QAT_ASSERT_IMPL(a_kind_range, res_valid, kind <= qat_pkg::KIND_OPEN_DOUBLE)

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_qat_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_stall (char_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.kind       (kind),
	.char_out   (char_out)
);
